// ===== hdl/mpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants for the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int ALPHABET_DEF  = 26;

    localparam int LETTER_W = 5;
    localparam int HITS_W   = 10;
    localparam int TOTAL_W  = 32;
    localparam int NODE_W   = 10;
    localparam int STATUS_W = 2;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_MATCH  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_CHK,
        ST_BLD_RD,
        ST_BLD_CHK,
        ST_BLD_SUF,
        ST_BLD_TRM,
        ST_BLD_STEP,
        ST_WALK_CHK,
        ST_WALK_SUF,
        ST_HIT_FIRST,
        ST_HIT_CHK,
        ST_HIT_NEXT,
        ST_PUSH
    } mpsm_state_t;

endpackage

// ===== hdl/multi_pattern_string_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick dictionary matcher with a trie in block memory and a sequencer
// that walks goto, suffix and terminal links one memory read at a time.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one letter per item. req_type 0 adds a pattern letter,
//   1 feeds a text letter; is_last closes the pattern or the text.
//   m_ channel: one result per item (hits, running total, node, status).
//   s_ready is high only while the sequencer is idle; one item is in work
//   at a time. A result waits in the output register while m_ready is low,
//   and the next item may be accepted meanwhile.
// Sequencing, set by the single read port of each table:
//   a refused or dropped insert goes straight to its result; any other
//   insert first reads its edge, and one creating a node then clears the
//   new node's ALPHABET edge entries.
//   A match letter reads its edge and adds reads per suffix hop of the
//   goto walk and per hit.
//   The first text letter after inserts first builds all suffix and terminal
//   links, sweeping every node once per trie depth level, then walks the letter.
// Reset: synchronous, active low; afterwards the root's ALPHABET edge
//   entries are cleared, one per cycle, before the first item is taken.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher #(
    parameter int MAX_NODES = mpsm_pkg::MAX_NODES_DEF,
    parameter int ALPHABET  = mpsm_pkg::ALPHABET_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [mpsm_pkg::LETTER_W-1:0]  s_letter,
    input  logic                           s_is_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mpsm_pkg::HITS_W-1:0]    m_hits,
    output logic [mpsm_pkg::TOTAL_W-1:0]   m_total,
    output logic [mpsm_pkg::NODE_W-1:0]    m_node,
    output logic [mpsm_pkg::STATUS_W-1:0]  m_status
);
    import mpsm_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int LW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CDEP  = MAX_NODES * ALPHABET;
    localparam int CAW   = $clog2(CDEP);
    localparam int AMW   = LETTER_W + 9;

    // edge entry: valid bit and child node
    typedef struct packed {
        logic          vld;
        logic [NW-1:0] child;
    } edge_t;

    // letter reduced modulo the alphabet, restoring subtract by constant
    function automatic logic [LW-1:0] reduce_letter(input logic [LETTER_W-1:0] l);
        logic [AMW-1:0] r;
        r = AMW'(l);
        for (int i = LETTER_W - 1; i >= 0; i--) begin
            if (r >= (AMW'(ALPHABET) << i)) begin
                r = r - (AMW'(ALPHABET) << i);
            end
        end
        return r[LW-1:0];
    endfunction

    function automatic logic [CAW-1:0] slot(input logic [NW-1:0] v, input logic [LW-1:0] c);
        return CAW'(CAW'(v) * CAW'(ALPHABET) + CAW'(c));
    endfunction

    // memories
    edge_t         child_mem [CDEP];
    logic [NW-1:0] suf_mem   [MAX_NODES];
    logic [NW-1:0] term_mem  [MAX_NODES];
    logic [NW-1:0] par_mem   [MAX_NODES];
    logic [LW-1:0] let_mem   [MAX_NODES];
    logic [NW-1:0] dep_mem   [MAX_NODES];
    logic          end_mem   [MAX_NODES];

    edge_t         child_q;
    logic [NW-1:0] suf_q, term_q, par_q, dep_q;
    logic [LW-1:0] let_q;
    logic          end_q;

    logic [CAW-1:0] crd_addr, child_waddr;
    edge_t          child_wdata;
    logic           child_we;
    logic [NW-1:0]  nrd_addr;
    logic           suf_we, term_we, node_we, end_we;
    logic [NW-1:0]  suf_waddr, suf_wdata, term_waddr, term_wdata;
    logic [NW-1:0]  node_waddr, end_waddr;
    logic           end_wdata;

    mpsm_state_t state_reg, state_next;

    logic [NW:0]            node_count_reg, node_count_next;
    logic [NW-1:0]          ins_cur_reg, ins_cur_next;
    logic [NW-1:0]          ins_depth_reg, ins_depth_next;
    logic [NW-1:0]          max_depth_reg, max_depth_next;
    logic                   dropped_reg, dropped_next;
    logic                   begun_reg, begun_next;
    logic [NW-1:0]          match_cur_reg, match_cur_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   req_reg, req_next;
    logic [LW-1:0]          c_reg, c_next;
    logic                   last_reg, last_next;
    logic [HITS_W-1:0]      hits_reg, hits_next;
    logic [NW-1:0]          rnode_reg, rnode_next;
    logic [STATUS_W-1:0]    rstatus_reg, rstatus_next;
    logic [NW-1:0]          walk_node_reg, walk_node_next;
    logic [LW-1:0]          walk_let_reg, walk_let_next;
    logic                   walk_bld_reg, walk_bld_next;
    logic [NW-1:0]          bld_node_reg, bld_node_next;
    logic [NW-1:0]          bld_depth_reg, bld_depth_next;
    logic [NW-1:0]          suf_res_reg, suf_res_next;
    logic [NW-1:0]          hit_node_reg, hit_node_next;
    logic [NW-1:0]          clr_node_reg, clr_node_next;
    logic [LW-1:0]          clr_idx_reg, clr_idx_next;
    logic                   clr_push_reg, clr_push_next;
    logic                   m_valid_reg, m_valid_next;
    logic [HITS_W-1:0]      m_hits_reg, m_hits_next;
    logic [TOTAL_W-1:0]     m_total_reg, m_total_next;
    logic [NODE_W-1:0]      m_node_reg, m_node_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;

    logic [LW-1:0]  c_in;
    logic           accept;
    logic           out_free;
    logic           full;
    logic           clr_done;
    logic           bld_more_nodes;
    logic [TOTAL_W:0] total_sum;

    assign c_in           = reduce_letter(s_letter);
    assign accept         = s_valid && s_ready;
    assign s_ready        = (state_reg == ST_IDLE);
    assign out_free       = !m_valid_reg || m_ready;
    assign full           = (node_count_reg >= (NW+1)'(MAX_NODES));
    assign clr_done       = (clr_idx_reg == LW'(ALPHABET - 1));
    assign bld_more_nodes = ((NW+1)'(bld_node_reg) + (NW+1)'(1)) < node_count_reg;
    assign total_sum      = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(hits_reg);

    // memory ports
    always_ff @(posedge aclk) begin
        if (child_we) begin
            child_mem[child_waddr] <= child_wdata;
        end
        child_q <= child_mem[crd_addr];
    end

    always_ff @(posedge aclk) begin
        if (suf_we) begin
            suf_mem[suf_waddr] <= suf_wdata;
        end
        suf_q <= suf_mem[nrd_addr];
    end

    always_ff @(posedge aclk) begin
        if (term_we) begin
            term_mem[term_waddr] <= term_wdata;
        end
        term_q <= term_mem[nrd_addr];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            par_mem[node_waddr] <= ins_cur_reg;
            let_mem[node_waddr] <= c_reg;
            dep_mem[node_waddr] <= ins_depth_reg + NW'(1);
        end
        par_q <= par_mem[nrd_addr];
        let_q <= let_mem[nrd_addr];
        dep_q <= dep_mem[nrd_addr];
    end

    always_ff @(posedge aclk) begin
        if (end_we) begin
            end_mem[end_waddr] <= end_wdata;
        end
        end_q <= end_mem[nrd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_done) begin
                    state_next = clr_push_reg ? ST_PUSH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_INSERT) begin
                        state_next = (begun_reg || dropped_reg) ? ST_PUSH : ST_INS_CHK;
                    end else if (!begun_reg && node_count_reg != (NW+1)'(1)) begin
                        state_next = ST_BLD_RD;
                    end else begin
                        state_next = ST_WALK_CHK;
                    end
                end
            end
            ST_INS_CHK: begin
                if (child_q.vld || full) begin
                    state_next = ST_PUSH;
                end else begin
                    state_next = ST_CLEAR;
                end
            end
            ST_BLD_RD:  state_next = ST_BLD_CHK;
            ST_BLD_CHK: begin
                if (dep_q != bld_depth_reg || par_q == '0) begin
                    state_next = ST_BLD_STEP;
                end else begin
                    state_next = ST_BLD_SUF;
                end
            end
            ST_BLD_SUF: state_next = ST_WALK_CHK;
            ST_BLD_TRM: state_next = ST_BLD_STEP;
            ST_BLD_STEP: begin
                if (bld_more_nodes || bld_depth_reg < max_depth_reg) begin
                    state_next = ST_BLD_RD;
                end else begin
                    state_next = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK: begin
                if (child_q.vld || walk_node_reg == '0) begin
                    if (walk_bld_reg) begin
                        state_next = (child_q.vld) ? ST_BLD_TRM : ST_BLD_STEP;
                    end else begin
                        state_next = (child_q.vld) ? ST_HIT_FIRST : ST_HIT_CHK;
                    end
                end else begin
                    state_next = ST_WALK_SUF;
                end
            end
            ST_WALK_SUF:  state_next = ST_WALK_CHK;
            ST_HIT_FIRST: state_next = ST_HIT_CHK;
            ST_HIT_CHK:   state_next = (hit_node_reg == '0) ? ST_PUSH : ST_HIT_NEXT;
            ST_HIT_NEXT:  state_next = ST_HIT_CHK;
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        node_count_next = node_count_reg;
        ins_cur_next    = ins_cur_reg;
        ins_depth_next  = ins_depth_reg;
        max_depth_next  = max_depth_reg;
        dropped_next    = dropped_reg;
        begun_next      = begun_reg;
        match_cur_next  = match_cur_reg;
        total_next      = total_reg;
        req_next        = req_reg;
        c_next          = c_reg;
        last_next       = last_reg;
        hits_next       = hits_reg;
        rnode_next      = rnode_reg;
        rstatus_next    = rstatus_reg;
        walk_node_next  = walk_node_reg;
        walk_let_next   = walk_let_reg;
        walk_bld_next   = walk_bld_reg;
        bld_node_next   = bld_node_reg;
        bld_depth_next  = bld_depth_reg;
        suf_res_next    = suf_res_reg;
        hit_node_next   = hit_node_reg;
        clr_node_next   = clr_node_reg;
        clr_idx_next    = clr_idx_reg;
        clr_push_next   = clr_push_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_hits_next     = m_hits_reg;
        m_total_next    = m_total_reg;
        m_node_next     = m_node_reg;
        m_status_next   = m_status_reg;

        crd_addr    = slot(walk_node_reg, walk_let_reg);
        child_we    = 1'b0;
        child_waddr = slot(ins_cur_reg, c_reg);
        child_wdata = '{vld: 1'b1, child: node_count_reg[NW-1:0]};
        nrd_addr    = bld_node_reg;
        suf_we      = 1'b0;
        suf_waddr   = bld_node_reg;
        suf_wdata   = '0;
        term_we     = 1'b0;
        term_waddr  = bld_node_reg;
        term_wdata  = '0;
        node_we     = 1'b0;
        node_waddr  = node_count_reg[NW-1:0];
        end_we      = 1'b0;
        end_waddr   = node_count_reg[NW-1:0];
        end_wdata   = last_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                child_we     = 1'b1;
                child_waddr  = slot(clr_node_reg, clr_idx_reg);
                child_wdata  = '0;
                clr_idx_next = clr_idx_reg + LW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    req_next     = s_req_type;
                    c_next       = c_in;
                    last_next    = s_is_last;
                    hits_next    = '0;
                    rstatus_next = STATUS_OK;
                    rnode_next   = ins_cur_reg;
                    crd_addr     = slot(ins_cur_reg, c_in);
                    if (s_req_type == REQ_INSERT) begin
                        if (begun_reg) begin
                            rstatus_next = STATUS_REFUSED;
                        end else if (dropped_reg) begin
                            rstatus_next = STATUS_FULL;
                            if (s_is_last) begin
                                ins_cur_next   = '0;
                                ins_depth_next = '0;
                                dropped_next   = 1'b0;
                            end
                        end
                    end else begin
                        begun_next     = 1'b1;
                        walk_let_next  = c_in;
                        walk_node_next = match_cur_reg;
                        walk_bld_next  = 1'b0;
                        crd_addr       = slot(match_cur_reg, c_in);
                        bld_node_next  = NW'(1);
                        bld_depth_next = NW'(1);
                    end
                end
            end
            ST_INS_CHK: begin
                if (child_q.vld) begin
                    rnode_next     = child_q.child;
                    ins_cur_next   = child_q.child;
                    ins_depth_next = ins_depth_reg + NW'(1);
                    if (last_reg) begin
                        end_we    = 1'b1;
                        end_waddr = child_q.child;
                        end_wdata = 1'b1;
                    end
                end else if (full) begin
                    rstatus_next = STATUS_FULL;
                    dropped_next = 1'b1;
                end else begin
                    child_we        = 1'b1;
                    node_we         = 1'b1;
                    end_we          = 1'b1;
                    node_count_next = node_count_reg + (NW+1)'(1);
                    rnode_next      = node_count_reg[NW-1:0];
                    ins_cur_next    = node_count_reg[NW-1:0];
                    ins_depth_next  = ins_depth_reg + NW'(1);
                    if (ins_depth_reg + NW'(1) > max_depth_reg) begin
                        max_depth_next = ins_depth_reg + NW'(1);
                    end
                    clr_node_next   = node_count_reg[NW-1:0];
                    clr_idx_next    = '0;
                    clr_push_next   = 1'b1;
                end
                // pattern end returns the cursor to the root
                if (last_reg) begin
                    ins_cur_next   = '0;
                    ins_depth_next = '0;
                    dropped_next   = 1'b0;
                end
            end
            ST_BLD_RD: begin
                nrd_addr = bld_node_reg;
            end
            ST_BLD_CHK: begin
                nrd_addr = par_q;
                walk_let_next = let_q;
                if (dep_q == bld_depth_reg && par_q == '0) begin
                    suf_we  = 1'b1;
                    term_we = 1'b1;
                end
            end
            ST_BLD_SUF: begin
                walk_node_next = suf_q;
                walk_bld_next  = 1'b1;
                crd_addr       = slot(suf_q, walk_let_reg);
            end
            ST_BLD_TRM: begin
                term_we    = 1'b1;
                term_wdata = end_q ? suf_res_reg : term_q;
            end
            ST_BLD_STEP: begin
                if (bld_more_nodes) begin
                    bld_node_next = bld_node_reg + NW'(1);
                end else if (bld_depth_reg < max_depth_reg) begin
                    bld_node_next  = NW'(1);
                    bld_depth_next = bld_depth_reg + NW'(1);
                end else begin
                    walk_let_next  = c_reg;
                    walk_node_next = match_cur_reg;
                    walk_bld_next  = 1'b0;
                    crd_addr       = slot(match_cur_reg, c_reg);
                end
            end
            ST_WALK_CHK: begin
                nrd_addr = walk_node_reg;
                if (child_q.vld || walk_node_reg == '0) begin
                    suf_res_next  = child_q.vld ? child_q.child : '0;
                    hit_node_next = '0;
                    nrd_addr      = child_q.child;
                    if (walk_bld_reg) begin
                        suf_we     = 1'b1;
                        suf_wdata  = child_q.vld ? child_q.child : '0;
                        // suffix at the root has the root as terminal too
                        term_we    = !child_q.vld;
                    end else begin
                        match_cur_next = child_q.vld ? child_q.child : '0;
                        rnode_next     = child_q.vld ? child_q.child : '0;
                    end
                end
            end
            ST_WALK_SUF: begin
                walk_node_next = suf_q;
                crd_addr       = slot(suf_q, walk_let_reg);
            end
            ST_HIT_FIRST: begin
                hit_node_next = end_q ? suf_res_reg : term_q;
            end
            ST_HIT_CHK: begin
                nrd_addr = hit_node_reg;
                if (hit_node_reg == '0) begin
                    total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                end else if (hits_reg != HITS_MAX) begin
                    hits_next = hits_reg + HITS_W'(1);
                end
            end
            ST_HIT_NEXT: begin
                hit_node_next = term_q;
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_hits_next   = hits_reg;
                    m_total_next  = total_reg;
                    m_node_next   = NODE_W'(rnode_reg);
                    m_status_next = rstatus_reg;
                    clr_push_next = 1'b0;
                    // end of text: back to the root, total cleared
                    if (req_reg == REQ_MATCH && last_reg) begin
                        match_cur_next = '0;
                        total_next     = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= (NW+1)'(1);
            ins_cur_reg    <= '0;
            ins_depth_reg  <= '0;
            max_depth_reg  <= '0;
            dropped_reg    <= 1'b0;
            begun_reg      <= 1'b0;
            match_cur_reg  <= '0;
            total_reg      <= '0;
            clr_node_reg   <= '0;
            clr_idx_reg    <= '0;
            clr_push_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            ins_cur_reg    <= ins_cur_next;
            ins_depth_reg  <= ins_depth_next;
            max_depth_reg  <= max_depth_next;
            dropped_reg    <= dropped_next;
            begun_reg      <= begun_next;
            match_cur_reg  <= match_cur_next;
            total_reg      <= total_next;
            clr_node_reg   <= clr_node_next;
            clr_idx_reg    <= clr_idx_next;
            clr_push_reg   <= clr_push_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        c_reg         <= c_next;
        last_reg      <= last_next;
        hits_reg      <= hits_next;
        rnode_reg     <= rnode_next;
        rstatus_reg   <= rstatus_next;
        walk_node_reg <= walk_node_next;
        walk_let_reg  <= walk_let_next;
        walk_bld_reg  <= walk_bld_next;
        bld_node_reg  <= bld_node_next;
        bld_depth_reg <= bld_depth_next;
        suf_res_reg   <= suf_res_next;
        hit_node_reg  <= hit_node_next;
        m_hits_reg    <= m_hits_next;
        m_total_reg   <= m_total_next;
        m_node_reg    <= m_node_next;
        m_status_reg  <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_hits   = m_hits_reg;
    assign m_total  = m_total_reg;
    assign m_node   = m_node_reg;
    assign m_status = m_status_reg;

endmodule
